### sv/gbrt_pkg.sv
// Shared types and constants for the grouped best-rated tracker.
package gbrt_pkg;

    localparam int ITEM_COUNT  = 256;
    localparam int GROUP_COUNT = 64;
    localparam int RATING_BITS = 16;

    localparam int ID_W     = $clog2(ITEM_COUNT);
    localparam int GROUP_W  = $clog2(GROUP_COUNT);

    // Field widths on the stream ports
    localparam int KIND_FW   = 2;
    localparam int ITEM_FW   = 8;
    localparam int GROUP_FW  = 6;
    localparam int RATING_FW = 16;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 8;

    typedef enum logic [KIND_FW-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_CHANGE = 2'd1,
        KIND_QUERY  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic change;
        logic start;
        logic step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } sts_t;

endpackage

### sv/gbrt_ctrl.sv
// Controller state machine: decodes transactions and sequences the table scan.
module gbrt_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_valid,
    input  logic [1:0]               in_kind,
    output logic                     in_ready,
    input  gbrt_pkg::sts_t           sts,
    output gbrt_pkg::cmd_t           cmd
);
    import gbrt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    case (kind_t'(in_kind))
                        KIND_LOAD:   cmd.load   = 1'b1;
                        KIND_CHANGE: cmd.change = 1'b1;
                        KIND_QUERY: begin
                            cmd.start  = 1'b1;
                            state_next = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.step = 1'b1;
                if (sts.last) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!sts.out_busy) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### sv/gbrt_dp.sv
// Datapath: item table, valid bits, scan compare and result register.
module gbrt_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  gbrt_pkg::cmd_t                 cmd,
    output gbrt_pkg::sts_t                 sts,
    input  logic [gbrt_pkg::ITEM_FW-1:0]   in_item,
    input  logic [gbrt_pkg::GROUP_FW-1:0]  in_group,
    input  logic [gbrt_pkg::RATING_FW-1:0] in_rating,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [gbrt_pkg::ITEM_FW-1:0]   out_best,
    output logic                           out_found
);
    import gbrt_pkg::*;

    logic [GROUP_W-1:0]     group_mem  [ITEM_COUNT];
    logic [RATING_BITS-1:0] rating_mem [ITEM_COUNT];
    logic [ITEM_COUNT-1:0]  valid_reg;

    logic [ID_W-1:0]        wr_idx;
    logic                   id_ok, group_ok;
    logic                   load_we, change_we;

    logic [ID_W-1:0]        cnt_reg;
    logic                   cmp_en_reg;
    logic [ID_W-1:0]        rd_id_reg;
    logic                   rd_valid_reg;
    logic [GROUP_W-1:0]     rd_group_reg;
    logic [RATING_BITS-1:0] rd_rating_reg;

    logic [GROUP_W-1:0]     query_group_reg;
    logic                   query_ok_reg;
    logic                   hit_reg;
    logic [ID_W-1:0]        best_id_reg;
    logic [RATING_BITS-1:0] best_rating_reg;
    logic                   take;

    logic                   m_valid_reg;
    logic [ITEM_FW-1:0]     m_best_reg;
    logic                   m_found_reg;

    assign wr_idx    = ID_W'(in_item);
    assign id_ok     = 32'(in_item) < ITEM_COUNT;
    assign group_ok  = 32'(in_group) < GROUP_COUNT;
    assign load_we   = cmd.load & id_ok & group_ok;
    assign change_we = cmd.change & id_ok & valid_reg[wr_idx];

    always_ff @(posedge aclk) begin
        if (load_we) begin
            group_mem[wr_idx] <= GROUP_W'(in_group);
        end
        if (load_we || change_we) begin
            rating_mem[wr_idx] <= RATING_BITS'(in_rating);
        end
        rd_group_reg  <= group_mem[cnt_reg];
        rd_rating_reg <= rating_mem[cnt_reg];
        rd_valid_reg  <= valid_reg[cnt_reg];
        rd_id_reg     <= cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (load_we) begin
            valid_reg[wr_idx] <= 1'b1;
        end
    end

    // Scan address and compare enable
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            cmp_en_reg <= 1'b0;
        end else begin
            cmp_en_reg <= cmd.step;
            if (cmd.start) begin
                cnt_reg <= '0;
            end else if (cmd.step) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign sts.last = cnt_reg == ID_W'(ITEM_COUNT - 1);

    // Strict greater-than keeps the lower id on a tie, since the scan ascends
    assign take = cmp_en_reg & query_ok_reg & rd_valid_reg
                & (rd_group_reg == query_group_reg)
                & (!hit_reg || (rd_rating_reg > best_rating_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (cmd.start) begin
            hit_reg <= 1'b0;
        end else if (take) begin
            hit_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            query_group_reg <= GROUP_W'(in_group);
            query_ok_reg    <= group_ok;
            best_id_reg     <= '0;
            best_rating_reg <= '0;
        end else if (take) begin
            best_id_reg     <= rd_id_reg;
            best_rating_reg <= rd_rating_reg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_best_reg  <= hit_reg ? ITEM_FW'(best_id_reg) : '0;
            m_found_reg <= hit_reg;
        end
    end

    assign sts.out_busy = m_valid_reg & ~out_ready;
    assign out_valid    = m_valid_reg;
    assign out_best     = m_best_reg;
    assign out_found    = m_found_reg;

endmodule

### sv/grouped_best_rated_tracker.sv
// Top level of the grouped best-rated tracker.
// The block holds a table of 256 items, each with a group, a 16-bit rating
// and a valid mark; reset clears all valid marks. A load or a change is
// written at the accepting edge and the next transaction may follow at once.
// A query walks the whole table through the read port of the item memory,
// one entry per cycle. Its result passes the registered compare and a
// flush state and is loaded into the output register in the emit state,
// and new input is taken only in idle. If the output register still holds
// an unread result when the scan ends, hold the new result and the input
// side until m_tready drains it. The result register frees the input side:
// once the result is loaded, new transactions are taken while it waits on
// m_tready. A query on a group with no valid item returns found = 0 and
// best_item = 0; ties go to the lower id.
module grouped_best_rated_tracker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [gbrt_pkg::S_DATA_W-1:0] s_tdata,  // item_id, group_id, rating, zero pad
    input  logic [gbrt_pkg::KIND_FW-1:0]  s_tuser,  // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gbrt_pkg::M_DATA_W-1:0] m_tdata,  // best_item
    output logic                          m_tuser   // found
);
    import gbrt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    logic [ITEM_FW-1:0]   in_item;
    logic [GROUP_FW-1:0]  in_group;
    logic [RATING_FW-1:0] in_rating;

    // Unpack the input transaction, lowest field first
    assign in_item   = s_tdata[ITEM_FW-1:0];
    assign in_group  = s_tdata[ITEM_FW+GROUP_FW-1:ITEM_FW];
    assign in_rating = s_tdata[ITEM_FW+GROUP_FW+RATING_FW-1:ITEM_FW+GROUP_FW];

    // Sequence: decode transaction kinds, run the scan, hand off the result
    gbrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_kind  (s_tuser),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Table, scan compare and output register
    gbrt_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_item   (in_item),
        .in_group  (in_group),
        .in_rating (in_rating),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_best  (m_tdata),
        .out_found (m_tuser)
    );

endmodule
